// File: src/jsoas_pkg.sv
// Shared types, character codes and helpers for the JSON object array scanner.
`default_nettype none

package jsoas_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int STATE_W = 4;
    localparam int OUT_TDATA_W = 16;

    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COLON    = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;

    typedef enum logic [STATE_W-1:0] {
        ST_OPEN_ARRAY  = 4'd0,
        ST_OPEN_OBJECT = 4'd1,
        ST_KEY_QUOTE   = 4'd2,
        ST_IN_KEY      = 4'd3,
        ST_COLON       = 4'd4,
        ST_VALUE       = 4'd5,
        ST_IN_STRING   = 4'd6,
        ST_IN_NUMBER   = 4'd7,
        ST_AFTER_VALUE = 4'd8,
        ST_AFTER_OBJ   = 4'd9,
        ST_TAIL        = 4'd10
    } t_scan_state;

    typedef enum logic [KIND_W-1:0] {
        KIND_OTHER  = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_STRING = 2'd2,
        KIND_NUMBER = 2'd3
    } t_byte_kind;

    typedef struct packed {
        t_scan_state state;
        logic        dot_seen;
        logic        error_latched;
    } t_scan;

    typedef struct packed {
        t_byte_kind        byte_kind;
        logic [BYTE_W-1:0] data_byte;
        logic              key_end;
        logic              value_end;
        logic              value_is_number;
        logic              object_end;
        logic              array_end;
        logic              accepted;
        logic              error;
    } t_result;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// File: src/json_object_array_scanner.sv
// Top level of the JSON object array scanner: input register, scan logic, result register.
`default_nettype none

// Streaming checker for a text that is an array of flat JSON objects whose members
// are a quoted key and a quoted string or unsigned number. Each input beat carries one
// text byte, or with tlast high the end of the text, and gives exactly one result beat
// that marks the byte's role, key, value, object and array ends, and at end of text
// the verdict (accepted or error). The block takes one beat per clock cycle unless the
// receiver holds back a result beat: the byte is registered, one pass through the scan
// logic updates the scan state and fills the result register. Only the scan state, a dot
// flag and the error flag carry from one byte to the next.
module json_object_array_scanner (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [7:0] text_byte
    input  wire [jsoas_pkg::BYTE_W-1:0]           i_s_axis_tdata,
    // end_of_text
    input  wire                                   i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // [7:0] data_byte, [8] key_end, [9] value_end, [10] value_is_number,
    // [11] object_end, [12] array_end, [13] accepted, [14] error, [15] zero
    output logic [jsoas_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // [1:0] byte_kind
    output logic [jsoas_pkg::KIND_W-1:0]          o_m_axis_tuser
);
    import jsoas_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    t_scan             r_scan;
    t_scan             n_scan;
    t_result           n_out;
    logic              advance;

    // The input stage moves on when the result register is empty or being drained.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    jsoas_step u_step (
        .i_scan        (r_scan),
        .i_text_byte   (r_in_byte),
        .i_end_of_text (r_in_last),
        .o_scan        (n_scan),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_scan.state         <= ST_OPEN_ARRAY;
            r_scan.dot_seen      <= 1'b0;
            r_scan.error_latched <= 1'b0;
        end else begin
            if (o_s_axis_tready) r_in_valid <= i_s_axis_tvalid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_scan      <= n_scan;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (advance) r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.byte_kind;
    assign o_m_axis_tdata  = {1'b0, r_out.error, r_out.accepted, r_out.array_end,
                              r_out.object_end, r_out.value_is_number, r_out.value_end,
                              r_out.key_end, r_out.data_byte};

    a_verdict_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.accepted && r_out.error))
        else $error("result beat is both accepted and in error");

    a_marks_without_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.key_end || r_out.value_end || r_out.object_end
                         || r_out.array_end || (r_out.byte_kind != KIND_OTHER)))
        |-> !r_out.error)
        else $error("role marks set on an error beat");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_last && r_scan.error_latched) |=> r_scan.error_latched)
        else $error("error flag cleared before end of text");

    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last)
        |=> (r_scan.state == ST_OPEN_ARRAY) && !r_scan.error_latched
            && (r_out.error != r_out.accepted))
        else $error("scan did not restart after end of text");

endmodule

`default_nettype wire

// File: src/jsoas_step.sv
// Next-state and result logic for one text byte of the scanner.
`default_nettype none

module jsoas_step (
    input  wire jsoas_pkg::t_scan             i_scan,
    input  wire [jsoas_pkg::BYTE_W-1:0]       i_text_byte,
    input  wire                               i_end_of_text,
    output jsoas_pkg::t_scan                  o_scan,
    output jsoas_pkg::t_result                o_result
);
    import jsoas_pkg::*;

    t_scan_state s;
    logic        dot;
    logic        bad;
    t_byte_kind  kind;
    logic        kend, vend, vnum, oend, aend;

    always_comb begin
        s    = i_scan.state;
        dot  = i_scan.dot_seen;
        bad  = 1'b0;
        kind = KIND_OTHER;
        kend = 1'b0;
        vend = 1'b0;
        vnum = 1'b0;
        oend = 1'b0;
        aend = 1'b0;

        unique case (i_scan.state)
            ST_OPEN_ARRAY: begin
                if (i_text_byte == CH_LBRACKET) s = ST_OPEN_OBJECT;
                else if (i_text_byte != CH_SPACE) bad = 1'b1;
            end
            ST_OPEN_OBJECT: begin
                if (i_text_byte == CH_LBRACE) s = ST_KEY_QUOTE;
                else if (i_text_byte != CH_SPACE) bad = 1'b1;
            end
            ST_KEY_QUOTE: begin
                if (i_text_byte == CH_QUOTE) s = ST_IN_KEY;
                else if (i_text_byte != CH_SPACE) bad = 1'b1;
            end
            ST_IN_KEY: begin
                if (i_text_byte == CH_QUOTE) begin
                    kend = 1'b1;
                    s    = ST_COLON;
                end else if (i_text_byte == CH_SPACE) begin
                    bad = 1'b1;
                end else begin
                    kind = KIND_KEY;
                end
            end
            ST_COLON: begin
                if (i_text_byte == CH_COLON) s = ST_VALUE;
                else if (i_text_byte != CH_SPACE) bad = 1'b1;
            end
            ST_VALUE: begin
                if (i_text_byte == CH_QUOTE) begin
                    s = ST_IN_STRING;
                end else if (is_digit(i_text_byte)) begin
                    kind = KIND_NUMBER;
                    dot  = 1'b0;
                    s    = ST_IN_NUMBER;
                end else if (i_text_byte != CH_SPACE) begin
                    bad = 1'b1;
                end
            end
            ST_IN_STRING: begin
                if (i_text_byte == CH_QUOTE) begin
                    vend = 1'b1;
                    s    = ST_AFTER_VALUE;
                end else begin
                    kind = KIND_STRING;
                end
            end
            ST_IN_NUMBER: begin
                if (is_digit(i_text_byte)) begin
                    kind = KIND_NUMBER;
                end else if (i_text_byte == CH_DOT && !i_scan.dot_seen) begin
                    kind = KIND_NUMBER;
                    dot  = 1'b1;
                end else if (i_text_byte == CH_SPACE) begin
                    vend = 1'b1;
                    vnum = 1'b1;
                    s    = ST_AFTER_VALUE;
                end else if (i_text_byte == CH_COMMA) begin
                    vend = 1'b1;
                    vnum = 1'b1;
                    s    = ST_KEY_QUOTE;
                end else if (i_text_byte == CH_RBRACE) begin
                    vend = 1'b1;
                    vnum = 1'b1;
                    oend = 1'b1;
                    s    = ST_AFTER_OBJ;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_AFTER_VALUE: begin
                if (i_text_byte == CH_COMMA) begin
                    s = ST_KEY_QUOTE;
                end else if (i_text_byte == CH_RBRACE) begin
                    oend = 1'b1;
                    s    = ST_AFTER_OBJ;
                end else if (i_text_byte != CH_SPACE) begin
                    bad = 1'b1;
                end
            end
            ST_AFTER_OBJ: begin
                if (i_text_byte == CH_COMMA) begin
                    s = ST_OPEN_OBJECT;
                end else if (i_text_byte == CH_RBRACKET) begin
                    aend = 1'b1;
                    s    = ST_TAIL;
                end else if (i_text_byte != CH_SPACE) begin
                    bad = 1'b1;
                end
            end
            ST_TAIL: begin
                if (i_text_byte != CH_SPACE) bad = 1'b1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        o_result = '0;
        if (i_end_of_text) begin
            // The verdict beat; the scan then restarts from its reset values.
            o_result.accepted = !i_scan.error_latched && (i_scan.state == ST_TAIL);
            o_result.error    = !o_result.accepted;
            o_scan.state         = ST_OPEN_ARRAY;
            o_scan.dot_seen      = 1'b0;
            o_scan.error_latched = 1'b0;
        end else if (i_scan.error_latched || bad) begin
            o_result.error = 1'b1;
            o_scan         = i_scan;
            o_scan.error_latched = 1'b1;
        end else begin
            o_result.byte_kind       = kind;
            o_result.data_byte       = (kind != KIND_OTHER) ? i_text_byte : '0;
            o_result.key_end         = kend;
            o_result.value_end       = vend;
            o_result.value_is_number = vnum;
            o_result.object_end      = oend;
            o_result.array_end       = aend;
            o_scan.state         = s;
            o_scan.dot_seen      = dot;
            o_scan.error_latched = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: tb/json_scan_checker.sv
// Checker for the JSON object array scanner: predicts each result beat and compares it.
`timescale 1ns / 100ps

module json_scan_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    input  wire                                i_s_tready,
    // [7:0] text_byte
    input  wire [jsoas_pkg::BYTE_W-1:0]        i_s_tdata,
    // end_of_text
    input  wire                                i_s_tlast,
    input  wire                                i_m_tvalid,
    input  wire                                i_m_tready,
    // [7:0] data_byte, [8] key_end, [9] value_end, [10] value_is_number,
    // [11] object_end, [12] array_end, [13] accepted, [14] error, [15] zero
    input  wire [jsoas_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    // [1:0] byte_kind
    input  wire [jsoas_pkg::KIND_W-1:0]        i_m_tuser,
    output int                                 o_mismatches = 0,
    output int                                 o_outstanding = 0
);
    import jsoas_pkg::*;

    t_scan_state scan_st     = ST_OPEN_ARRAY;
    logic        num_dot     = 1'b0;
    logic        scan_failed = 1'b0;

    t_result     expected_results[$];
    int          mismatch_count = 0;
    int          result_idx = 0;

    function automatic t_result scan_next_byte(input logic [BYTE_W-1:0] ch, input logic eot);
        t_result     r;
        t_scan_state nxt;
        logic        bad;
        logic        digit;
        r = '0;
        if (eot) begin
            r.accepted  = !scan_failed && (scan_st == ST_TAIL);
            r.error     = !r.accepted;
            scan_st     = ST_OPEN_ARRAY;
            num_dot     = 1'b0;
            scan_failed = 1'b0;
            return r;
        end
        if (scan_failed) begin
            r.error = 1'b1;
            return r;
        end
        nxt   = scan_st;
        bad   = 1'b0;
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        case (scan_st)
            ST_OPEN_ARRAY: begin
                if (ch == CH_LBRACKET) nxt = ST_OPEN_OBJECT;
                else if (ch != CH_SPACE) bad = 1'b1;
            end
            ST_OPEN_OBJECT: begin
                if (ch == CH_LBRACE) nxt = ST_KEY_QUOTE;
                else if (ch != CH_SPACE) bad = 1'b1;
            end
            ST_KEY_QUOTE: begin
                if (ch == CH_QUOTE) nxt = ST_IN_KEY;
                else if (ch != CH_SPACE) bad = 1'b1;
            end
            ST_IN_KEY: begin
                if (ch == CH_QUOTE) begin
                    r.key_end = 1'b1;
                    nxt = ST_COLON;
                end else if (ch == CH_SPACE) begin
                    bad = 1'b1;
                end else begin
                    r.byte_kind = KIND_KEY;
                end
            end
            ST_COLON: begin
                if (ch == CH_COLON) nxt = ST_VALUE;
                else if (ch != CH_SPACE) bad = 1'b1;
            end
            ST_VALUE: begin
                if (ch == CH_QUOTE) begin
                    nxt = ST_IN_STRING;
                end else if (digit) begin
                    r.byte_kind = KIND_NUMBER;
                    num_dot = 1'b0;
                    nxt = ST_IN_NUMBER;
                end else if (ch != CH_SPACE) begin
                    bad = 1'b1;
                end
            end
            ST_IN_STRING: begin
                if (ch == CH_QUOTE) begin
                    r.value_end = 1'b1;
                    nxt = ST_AFTER_VALUE;
                end else begin
                    r.byte_kind = KIND_STRING;
                end
            end
            ST_IN_NUMBER: begin
                if (digit) begin
                    r.byte_kind = KIND_NUMBER;
                end else if (ch == CH_DOT && !num_dot) begin
                    r.byte_kind = KIND_NUMBER;
                    num_dot = 1'b1;
                end else if (ch == CH_SPACE || ch == CH_COMMA || ch == CH_RBRACE) begin
                    // Any of these terminates the number and then acts as itself.
                    r.value_end       = 1'b1;
                    r.value_is_number = 1'b1;
                    if (ch == CH_SPACE) begin
                        nxt = ST_AFTER_VALUE;
                    end else if (ch == CH_COMMA) begin
                        nxt = ST_KEY_QUOTE;
                    end else begin
                        r.object_end = 1'b1;
                        nxt = ST_AFTER_OBJ;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            ST_AFTER_VALUE: begin
                if (ch == CH_COMMA) begin
                    nxt = ST_KEY_QUOTE;
                end else if (ch == CH_RBRACE) begin
                    r.object_end = 1'b1;
                    nxt = ST_AFTER_OBJ;
                end else if (ch != CH_SPACE) begin
                    bad = 1'b1;
                end
            end
            ST_AFTER_OBJ: begin
                if (ch == CH_COMMA) begin
                    nxt = ST_OPEN_OBJECT;
                end else if (ch == CH_RBRACKET) begin
                    r.array_end = 1'b1;
                    nxt = ST_TAIL;
                end else if (ch != CH_SPACE) begin
                    bad = 1'b1;
                end
            end
            ST_TAIL: begin
                if (ch != CH_SPACE) bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            scan_failed = 1'b1;
            r = '0;
        end else begin
            scan_st = nxt;
        end
        r.data_byte = (r.byte_kind != KIND_OTHER) ? ch : '0;
        r.error     = scan_failed;
        return r;
    endfunction

    function automatic logic fields_differ(input t_result want, input t_result got);
        return (want.byte_kind       !== got.byte_kind)
            || (want.data_byte       !== got.data_byte)
            || (want.key_end         !== got.key_end)
            || (want.value_end       !== got.value_end)
            || (want.value_is_number !== got.value_is_number)
            || (want.object_end      !== got.object_end)
            || (want.array_end       !== got.array_end)
            || (want.accepted        !== got.accepted)
            || (want.error           !== got.error);
    endfunction

    function automatic void show_result(input string tag, input t_result r);
        $display("  %s kind=%0d data=%02h key_end=%b value_end=%b number=%b obj_end=%b",
                 tag, r.byte_kind, r.data_byte, r.key_end, r.value_end,
                 r.value_is_number, r.object_end);
        $display("  %s arr_end=%b accepted=%b error=%b",
                 tag, r.array_end, r.accepted, r.error);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            scan_st     = ST_OPEN_ARRAY;
            num_dot     = 1'b0;
            scan_failed = 1'b0;
            expected_results.delete();
            o_outstanding <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(scan_next_byte(i_s_tdata, i_s_tlast));
            if (i_m_tvalid && i_m_tready) begin
                got.byte_kind       = t_byte_kind'(i_m_tuser);
                got.data_byte       = i_m_tdata[7:0];
                got.key_end         = i_m_tdata[8];
                got.value_end       = i_m_tdata[9];
                got.value_is_number = i_m_tdata[10];
                got.object_end      = i_m_tdata[11];
                got.array_end       = i_m_tdata[12];
                got.accepted        = i_m_tdata[13];
                got.error           = i_m_tdata[14];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result beat %0d arrived with no beat outstanding", result_idx);
                        show_result("got", got);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (fields_differ(want, got)) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result beat %0d differs", result_idx);
                            show_result("expected", want);
                            show_result("got     ", got);
                        end
                    end
                end
                result_idx++;
            end
            o_outstanding <= expected_results.size();
        end
        o_mismatches <= mismatch_count;
    end

endmodule

// File: tb/tb.sv
// Testbench top for the JSON object array scanner: clock, reset, text stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import jsoas_pkg::*;

    localparam int ITEM_TARGET    = 1450;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              eot;
        logic [BYTE_W-1:0] ch;
    } t_text_beat;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    logic [BYTE_W-1:0]      s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    wire  [OUT_TDATA_W-1:0] m_tdata;
    wire  [KIND_W-1:0]      m_tuser;

    int mismatches;
    int outstanding;

    t_text_beat staged[$];
    int         items_sent  = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;
    int         stall_mode  = 0;
    int         stall_left  = 0;
    int         stall_phase = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    json_object_array_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    json_scan_checker u_scan_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // The receiver switches at random between four stall patterns.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_phase % 8) >= 5;
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void add_byte(input logic [BYTE_W-1:0] ch);
        staged.push_back('{eot: 1'b0, ch: ch});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    // The byte that rides along with the end marker is random, since it is ignored.
    function automatic void add_end();
        staged.push_back('{eot: 1'b1, ch: BYTE_W'($urandom_range(0, 255))});
    endfunction

    function automatic void add_spaces();
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0) add_byte(CH_SPACE);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte_except(input logic [BYTE_W-1:0] a,
                                                           input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(0, 255)); while (c == a || c == b);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_token_byte();
        case ($urandom_range(0, 11))
            0: return CH_LBRACKET;
            1: return CH_LBRACE;
            2: return CH_QUOTE;
            3: return CH_COLON;
            4: return CH_COMMA;
            5: return CH_RBRACE;
            6: return CH_RBRACKET;
            7: return CH_DOT;
            8: return CH_SPACE;
            9: return BYTE_W'(CH_ZERO + $urandom_range(0, 9));
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_number();
        logic dot_used;
        dot_used = 1'b0;
        add_byte(BYTE_W'(CH_ZERO + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 4)) begin
            if (!dot_used && $urandom_range(0, 3) == 0) begin
                add_byte(CH_DOT);
                dot_used = 1'b1;
            end else begin
                add_byte(BYTE_W'(CH_ZERO + $urandom_range(0, 9)));
            end
        end
    endfunction

    // A well-formed array of flat objects with random keys, values and spacing.
    function automatic void stage_array_text();
        int n_obj;
        int n_mem;
        add_spaces();
        add_byte(CH_LBRACKET);
        n_obj = $urandom_range(1, 3);
        for (int o = 0; o < n_obj; o++) begin
            add_spaces();
            add_byte(CH_LBRACE);
            n_mem = $urandom_range(1, 3);
            for (int m = 0; m < n_mem; m++) begin
                add_spaces();
                add_byte(CH_QUOTE);
                repeat ($urandom_range(0, 4)) add_byte(pick_byte_except(CH_QUOTE, CH_SPACE));
                add_byte(CH_QUOTE);
                add_spaces();
                add_byte(CH_COLON);
                add_spaces();
                if ($urandom_range(0, 1) == 1) begin
                    add_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 4)) add_byte(pick_byte_except(CH_QUOTE, CH_QUOTE));
                    add_byte(CH_QUOTE);
                end else begin
                    add_number();
                end
                add_spaces();
                add_byte((m == n_mem - 1) ? CH_RBRACE : CH_COMMA);
            end
            add_spaces();
            if (o != n_obj - 1) add_byte(CH_COMMA);
        end
        add_byte(CH_RBRACKET);
        add_spaces();
        add_end();
    endfunction

    function automatic void corrupt_staged();
        int idx;
        idx = $urandom_range(0, staged.size() - 2);
        case ($urandom_range(0, 3))
            0: staged[idx].ch = pick_token_byte();
            1: staged.insert(idx, '{eot: 1'b0, ch: pick_token_byte()});
            2: begin
                // Cut the text short with an early end marker.
                staged = staged[0:idx];
                staged[idx].eot = 1'b1;
            end
            default: staged.delete(staged.size() - 1);
        endcase
    endfunction

    task automatic send_beat(input t_text_beat b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b.ch;
        s_tlast  <= b.eot;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_staged();
        while (staged.size() > 0) send_beat(staged.pop_front());
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        int pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero key byte, all-ones string byte, leading and trailing spaces: accepted.
        add_text(" [{\"");
        add_byte(8'h00);
        add_text("\":\"");
        add_byte(8'hFF);
        add_text("\"}] ");
        add_end();
        // Second dot in a number, a byte after the error, then end of text mid-array.
        add_text("[{\"k\":1.2.3");
        add_end();
        send_staged();

        // Let the block run completely dry once before the random part.
        s_tvalid <= 1'b0;
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 12)) add_byte(pick_token_byte());
                add_end();
            end else begin
                stage_array_text();
                if (pick <= 2) corrupt_staged();
            end
            send_staged();
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: json_object_array_scanner.f
src/jsoas_pkg.sv
src/jsoas_step.sv
src/json_object_array_scanner.sv
tb/json_scan_checker.sv
tb/tb.sv
